>>> design/fqu_pkg.sv
// Shared types and codes for the unique-key queue.
`default_nettype none
package fqu_pkg;

	localparam int KEY_W   = 31;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_RANGE = 2'd1;
	localparam logic [1:0] STAT_DUP   = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	typedef struct packed {
		logic [1:0]                mode;
		logic [KEY_W-1:0]          item_key;
		logic signed [VALUE_W-1:0] item_value;
		logic [POS_W-1:0]          position;
	} fqu_cmd_t;

	typedef struct packed {
		logic [1:0]                status;
		logic [KEY_W-1:0]          out_key;
		logic signed [VALUE_W-1:0] out_value;
		logic [POS_W-1:0]          entry_count;
	} fqu_rsp_t;

endpackage
`default_nettype wire

>>> design/fqu_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fqu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> design/fifo_queue_unique_keys.sv
// Top level: ring-buffer queue of key/value pairs with a sequential duplicate-key search.
// Commands enter on start when busy is low and each produces exactly one result, shown on
// rsp for the single cycle in which done is high; the receiver cannot stall it, so capture
// it then. Insert reads the stored keys one per cycle through the key RAM's read port and
// compares each against the new key, so its time from start to done grows with occupancy.
// Remove and read go on to a fetch state; a full insert, an empty remove, an out-of-range
// read or an unused mode ends in the execute state. busy is high from the accepting edge
// until the cycle of done. Storage needs no clearing after reset.
`default_nettype none
module fifo_queue_unique_keys
	import fqu_pkg::*;
#(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire fqu_cmd_t cmd,
	output logic          busy,
	output logic          done,
	output fqu_rsp_t      rsp
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam logic [AW:0] DEPTH_W = (AW + 1)'(QUEUE_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_FETCH
	} state_t;

	state_t           state_q;
	fqu_cmd_t         cmd_q;
	logic [AW-1:0]    head_q;
	logic [CW-1:0]    occ_q;
	logic [CW-1:0]    idx_q;
	logic             cmp_vld_s1;
	fqu_rsp_t         rsp_q;
	logic             done_q;

	logic [AW-1:0]    offset;
	logic [AW:0]      slot_sum;
	logic [AW-1:0]    slot;
	logic [PW-1:0]    pos_w;
	logic [PW-1:0]    occ_w;
	logic [PW-1:0]    pos_m1;
	logic             pos_ok;
	logic             rd_en;
	logic             wr_en;
	logic [KEY_W-1:0] key_rd;
	logic [VALUE_W-1:0] val_rd;
	logic             key_hit;

	assign pos_w  = PW'(cmd_q.position);
	assign occ_w  = PW'(occ_q);
	assign pos_m1 = pos_w - PW'(1);
	assign pos_ok = (pos_w != '0) && (pos_w <= occ_w);

	// Offset from the head for whichever access this state needs.
	always_comb begin
		offset = '0;
		unique case (state_q)
			ST_EXEC: begin
				if (cmd_q.mode == MODE_READ) begin
					offset = pos_m1[AW-1:0];
				end
			end
			ST_SCAN:  offset = idx_q[AW-1:0];
			ST_FETCH: offset = AW'(1);
			default:  offset = '0;
		endcase
	end

	// Offsets stay below the depth, so one compare and subtract wraps the ring.
	always_comb begin
		slot_sum = {1'b0, head_q} + {1'b0, offset};
		if (slot_sum >= DEPTH_W) begin
			slot_sum = slot_sum - DEPTH_W;
		end
		slot = slot_sum[AW-1:0];
	end

	assign rd_en   = (state_q == ST_EXEC) || ((state_q == ST_SCAN) && (idx_q != occ_q));
	assign key_hit = cmp_vld_s1 && (key_rd == cmd_q.item_key);
	assign wr_en   = (state_q == ST_SCAN) && !key_hit && (idx_q == occ_q);

	fqu_ram #(
		.WIDTH(KEY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot),
		.wr_data (cmd_q.item_key),
		.rd_en   (rd_en),
		.rd_addr (slot),
		.rd_data (key_rd)
	);

	fqu_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(QUEUE_DEPTH)
	) u_value_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot),
		.wr_data (cmd_q.item_value),
		.rd_en   (rd_en),
		.rd_addr (slot),
		.rd_data (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			occ_q      <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
			cmd_q      <= '0;
			rsp_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					rsp_q             <= '0;
					rsp_q.status      <= STAT_RANGE;
					rsp_q.entry_count <= POS_W'(occ_q);
					idx_q             <= '0;
					cmp_vld_s1        <= 1'b0;
					case (cmd_q.mode)
						MODE_INSERT: begin
							if (occ_q == DEPTH_C) begin
								rsp_q.status <= STAT_FULL;
								done_q       <= 1'b1;
								state_q      <= ST_IDLE;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						MODE_REMOVE: begin
							if (occ_q != '0) begin
								state_q <= ST_FETCH;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						MODE_READ: begin
							if (pos_ok) begin
								state_q <= ST_FETCH;
							end else begin
								done_q  <= 1'b1;
								state_q <= ST_IDLE;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_SCAN: begin
					// Compare the key fetched last cycle while issuing the next read.
					if (key_hit) begin
						rsp_q.status <= STAT_DUP;
						done_q       <= 1'b1;
						state_q      <= ST_IDLE;
					end else if (idx_q == occ_q) begin
						occ_q             <= occ_q + CW'(1);
						rsp_q.status      <= STAT_OK;
						rsp_q.entry_count <= POS_W'(occ_q + CW'(1));
						done_q            <= 1'b1;
						state_q           <= ST_IDLE;
					end else begin
						idx_q      <= idx_q + CW'(1);
						cmp_vld_s1 <= 1'b1;
					end
				end
				ST_FETCH: begin
					rsp_q.status    <= STAT_OK;
					rsp_q.out_key   <= key_rd;
					rsp_q.out_value <= val_rd;
					if (cmd_q.mode == MODE_REMOVE) begin
						head_q            <= slot;
						occ_q             <= occ_q - CW'(1);
						rsp_q.entry_count <= POS_W'(occ_q - CW'(1));
					end
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
`default_nettype wire

>>> tb/sv/fifo_queue_unique_keys_tb.sv
// Self-checking testbench for the unique-key queue: directed corner cases, then random traffic.
module fifo_queue_unique_keys_tb;
	import fqu_pkg::*;

	localparam int DEPTH        = 64;
	localparam int RANDOM_ITEMS = 1300;
	localparam int QUIET_TAIL   = 150;
	localparam int CYCLE_LIMIT  = 500000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Tracks the queue contents and the pending responses.
	class queue_scoreboard;
		fqu_rsp_t         pending_rsp[$];
		logic [KEY_W-1:0]   keys[DEPTH];
		logic [VALUE_W-1:0] values[DEPTH];
		int unsigned      head;
		int unsigned      count;
		int               fails;
		int               checked;
		int               status_seen[4];
		int               peak;

		function new();
			head    = 0;
			count   = 0;
			fails   = 0;
			checked = 0;
			peak    = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		function bit holds_key(logic [KEY_W-1:0] k);
			for (int i = 0; i < count; i++)
				if (keys[(head + i) % DEPTH] == k) return 1;
			return 0;
		endfunction

		// Apply one accepted command to the shadow queue and queue up its response.
		function void note_command(fqu_cmd_t c);
			fqu_rsp_t    r;
			int unsigned s;
			r = '0;
			r.status = STAT_RANGE;
			case (c.mode)
				MODE_INSERT: begin
					if (count >= DEPTH) begin
						r.status = STAT_FULL;
					end else if (holds_key(c.item_key)) begin
						r.status = STAT_DUP;
					end else begin
						s = (head + count) % DEPTH;
						keys[s]   = c.item_key;
						values[s] = c.item_value;
						count++;
						r.status = STAT_OK;
					end
				end
				MODE_REMOVE: begin
					if (count != 0) begin
						r.out_key   = keys[head];
						r.out_value = values[head];
						head = (head + 1) % DEPTH;
						count--;
						r.status = STAT_OK;
					end
				end
				MODE_READ: begin
					if (c.position >= 1 && c.position <= count) begin
						s = (head + c.position - 1) % DEPTH;
						r.out_key   = keys[s];
						r.out_value = values[s];
						r.status    = STAT_OK;
					end
				end
				default: ;
			endcase
			r.entry_count = count[POS_W-1:0];
			if (count > peak) peak = count;
			pending_rsp.push_back(r);
		endfunction

		function void check_result(fqu_rsp_t got);
			fqu_rsp_t want;
			if (pending_rsp.size() == 0) begin
				$error("response with no command outstanding: status %0d key %0h",
					got.status, got.out_key);
				fails++;
				return;
			end
			want = pending_rsp.pop_front();
			checked++;
			status_seen[want.status]++;
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				fails++;
			end
			if (got.out_key !== want.out_key) begin
				$error("out_key: expected %0h, got %0h", want.out_key, got.out_key);
				fails++;
			end
			if (got.out_value !== want.out_value) begin
				$error("out_value: expected %0d, got %0d", want.out_value, got.out_value);
				fails++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					got.entry_count);
				fails++;
			end
		endfunction
	endclass

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	fqu_cmd_t cmd = '0;
	logic     busy;
	logic     done;
	fqu_rsp_t rsp;
	int       cycles = 0;

	queue_scoreboard sb = new();

	fifo_queue_unique_keys #(.QUEUE_DEPTH(DEPTH)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done) sb.check_result(rsp);

	function automatic fqu_cmd_t make_cmd(logic [1:0] m, logic [KEY_W-1:0] k,
			logic [VALUE_W-1:0] v, logic [POS_W-1:0] p);
		fqu_cmd_t c;
		c.mode       = m;
		c.item_key   = k;
		c.item_value = v;
		c.position   = p;
		return c;
	endfunction

	// Drive one item and hold it until the block takes it; start stays high afterwards.
	task automatic issue(fqu_cmd_t c, bit may_idle);
		if (may_idle && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	// Insert-heavy phases push the queue to full, drain phases empty it again.
	function automatic fqu_cmd_t random_cmd(bit filling);
		fqu_cmd_t c;
		int       r;
		int       pick;
		c.item_key   = KEY_W'($urandom);
		c.item_value = $urandom;
		c.position   = POS_W'($urandom_range(0, 127));
		r = $urandom_range(0, 99);
		if (r < 2)
			c.mode = MODE_UNUSED;
		else if (r < (filling ? 72 : 17))
			c.mode = MODE_INSERT;
		else if (r < (filling ? 87 : 72))
			c.mode = MODE_REMOVE;
		else
			c.mode = MODE_READ;
		pick = $urandom_range(0, 99);
		if (pick < 25 && sb.count > 0)
			c.item_key = sb.keys[(sb.head + $urandom_range(0, sb.count - 1)) % DEPTH];
		else if (pick < 40)
			c.item_key = KEY_W'($urandom_range(0, 15));
		if ($urandom_range(0, 4) != 0)
			c.position = POS_W'($urandom_range(0, sb.count + 1));
		return c;
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unused mode, key and value extremes, duplicates at head and tail
		issue(make_cmd(MODE_REMOVE, 31'h7fffffff, 32'hffffffff, 7'd1), 0);
		issue(make_cmd(MODE_READ, 31'd5, 32'd5, 7'd1), 0);
		issue(make_cmd(MODE_UNUSED, 31'h7fffffff, 32'h80000000, 7'd127), 0);
		issue(make_cmd(MODE_INSERT, 31'd0, 32'h80000000, 7'd0), 0);
		issue(make_cmd(MODE_INSERT, 31'h7fffffff, 32'h7fffffff, 7'd127), 0);
		issue(make_cmd(MODE_INSERT, 31'd0, 32'd1, 7'd0), 0);
		issue(make_cmd(MODE_INSERT, 31'h7fffffff, 32'd2, 7'd0), 1);
		issue(make_cmd(MODE_INSERT, 31'h2aaaaaaa, 32'hffffffff, 7'h55), 1);
		issue(make_cmd(MODE_INSERT, 31'h7fffffff, 32'd3, 7'd0), 1);
		issue(make_cmd(MODE_READ, 31'd0, 32'd0, 7'd0), 1);
		issue(make_cmd(MODE_READ, 31'd0, 32'd0, 7'd1), 1);
		issue(make_cmd(MODE_READ, 31'd0, 32'd0, 7'd3), 1);
		issue(make_cmd(MODE_READ, 31'd0, 32'd0, 7'd4), 1);
		issue(make_cmd(MODE_READ, 31'd0, 32'd0, 7'd127), 1);
		issue(make_cmd(MODE_UNUSED, 31'h55555555, 32'h55555555, 7'd2), 1);
		issue(make_cmd(MODE_REMOVE, 31'd0, 32'd0, 7'd0), 1);
		issue(make_cmd(MODE_READ, 31'd0, 32'd0, 7'd1), 1);
		issue(make_cmd(MODE_INSERT, 31'd0, 32'd0, 7'd0), 1);
		issue(make_cmd(MODE_REMOVE, 31'd0, 32'd0, 7'd0), 1);
		issue(make_cmd(MODE_REMOVE, 31'd0, 32'd0, 7'd0), 1);
		issue(make_cmd(MODE_REMOVE, 31'd0, 32'd0, 7'd0), 1);
		issue(make_cmd(MODE_REMOVE, 31'd0, 32'd0, 7'd0), 0);

		for (int i = 0; i < RANDOM_ITEMS; i++)
			issue(random_cmd(((i / 80) % 4) < 2), i < RANDOM_ITEMS - QUIET_TAIL);
		start <= 1'b0;

		while (sb.pending_rsp.size() != 0) @(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		$display("checked %0d responses: %0d ok, %0d empty/out of range, %0d duplicate, %0d full",
			sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_RANGE],
			sb.status_seen[STAT_DUP], sb.status_seen[STAT_FULL]);
		$display("peak occupancy %0d of %0d entries, %0d cycles", sb.peak, DEPTH, cycles);
		if (sb.fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
